### sv/gqi_pkg.sv
// constants, types and operand tables for the gyro quaternion integrator
// no dependencies; imported by gyro_quaternion_integrator_top
package gqi_pkg;

	localparam int FRAC_BITS_DEF = 30;
	localparam int RATE_BITS_DEF = 16;

	localparam int KIND_W     = 2;
	localparam int TIME_W     = 48;
	localparam int RATE_W     = 16;
	localparam int GAP_W      = 20;
	localparam int MAT_W      = 32;
	localparam int IN_DATA_W  = 2 * TIME_W + 3 * RATE_W;
	localparam int OUT_DATA_W = 9 * MAT_W;

	localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

	localparam logic [GAP_W-1:0] GAP_RESET = 20'd100000;
	localparam logic [31:0]      H_DIVISOR = 32'd62500;
	localparam logic [63:0]      H_ROUND   = 64'd31250;
	localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

	// one product term of the quaternion update
	typedef struct packed {
		logic [1:0] tgt;
		logic [1:0] hsel;
		logic [1:0] qsel;
		logic       neg;
	} u_term_t;

	// one product term of the rotation matrix
	typedef struct packed {
		logic [1:0] asel;
		logic [1:0] bsel;
		logic       sub;
		logic       diag;
	} m_term_t;

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic u_term_t u_term(input logic [3:0] k);
		u_term_t t;
		unique case (k)
			4'd0:    t = '{2'd0, 2'd0, 2'd3, 1'b0};
			4'd1:    t = '{2'd0, 2'd1, 2'd2, 1'b0};
			4'd2:    t = '{2'd0, 2'd2, 2'd1, 1'b1};
			4'd3:    t = '{2'd1, 2'd1, 2'd3, 1'b0};
			4'd4:    t = '{2'd1, 2'd2, 2'd0, 1'b0};
			4'd5:    t = '{2'd1, 2'd0, 2'd2, 1'b1};
			4'd6:    t = '{2'd2, 2'd2, 2'd3, 1'b0};
			4'd7:    t = '{2'd2, 2'd0, 2'd1, 1'b0};
			4'd8:    t = '{2'd2, 2'd1, 2'd0, 1'b1};
			4'd9:    t = '{2'd3, 2'd0, 2'd0, 1'b1};
			4'd10:   t = '{2'd3, 2'd1, 2'd1, 1'b1};
			4'd11:   t = '{2'd3, 2'd2, 2'd2, 1'b1};
			default: t = '{2'd0, 2'd0, 2'd0, 1'b0};
		endcase
		return t;
	endfunction

	// k[4:1] is the matrix element, k[0] its first or second product
	function automatic m_term_t m_term(input logic [4:0] k);
		logic [1:0] a0, b0, a1, b1;
		logic       sub, diag;
		a0 = 2'd0; b0 = 2'd0; a1 = 2'd0; b1 = 2'd0; sub = 1'b0; diag = 1'b0;
		unique case (k[4:1])
			4'd0: begin a0 = 2'd1; b0 = 2'd1; a1 = 2'd2; b1 = 2'd2; diag = 1'b1; end
			4'd1: begin a0 = 2'd0; b0 = 2'd1; a1 = 2'd3; b1 = 2'd2; sub = 1'b1; end
			4'd2: begin a0 = 2'd0; b0 = 2'd2; a1 = 2'd3; b1 = 2'd1; end
			4'd3: begin a0 = 2'd0; b0 = 2'd1; a1 = 2'd3; b1 = 2'd2; end
			4'd4: begin a0 = 2'd0; b0 = 2'd0; a1 = 2'd2; b1 = 2'd2; diag = 1'b1; end
			4'd5: begin a0 = 2'd1; b0 = 2'd2; a1 = 2'd3; b1 = 2'd0; sub = 1'b1; end
			4'd6: begin a0 = 2'd0; b0 = 2'd2; a1 = 2'd3; b1 = 2'd1; sub = 1'b1; end
			4'd7: begin a0 = 2'd1; b0 = 2'd2; a1 = 2'd3; b1 = 2'd0; end
			4'd8: begin a0 = 2'd0; b0 = 2'd0; a1 = 2'd1; b1 = 2'd1; diag = 1'b1; end
			default: begin end
		endcase
		return k[0] ? m_term_t'{a1, b1, sub, diag} : m_term_t'{a0, b0, 1'b0, diag};
	endfunction

endpackage

### sv/gyro_quaternion_integrator_top.sv
// gyro quaternion integrator: window bookkeeping, bit-serial arithmetic, matrix output
// depends on gqi_pkg
//
// channel  direction  handshake             payload
// cfg      in         cfg_valid/cfg_ready   cfg_data = max_gap_us
// s        in         s_tvalid/s_tready     s_tdata, s_tuser = kind
// m        out        m_tvalid/m_tready     m_tdata = matrix, m_tuser = skipped
//
// begin, ignored kinds and samples that are not integrated are handled in S_IDLE, an identity finish
// also passes S_EMIT. an integrated sample is worked by the shared shift-add multiplier and the
// restoring divider, with a square root in between; a finish with a matrix uses only the
// shared multiplier.
// reset is asynchronous; there is no clearing pass. s_tready is low while a sample or
// matrix is being worked; a finished matrix waits in the output register for m_tready.
module gyro_quaternion_integrator_top #(
	parameter int FRAC_BITS = gqi_pkg::FRAC_BITS_DEF,
	parameter int RATE_BITS = gqi_pkg::RATE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gqi_pkg::GAP_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// time_us, window_end_us, rate_x, rate_y, rate_z
	input  logic [gqi_pkg::IN_DATA_W-1:0]   s_tdata,
	// kind
	input  logic [gqi_pkg::KIND_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic [gqi_pkg::OUT_DATA_W-1:0]  m_tdata,
	// skipped
	output logic [0:0]                      m_tuser
);
	import gqi_pkg::*;

	localparam logic [31:0] R_MASK = 32'((64'd1 << RATE_BITS) - 64'd1);
	localparam logic [31:0] R_SIGN = 32'(64'd1 << (RATE_BITS - 1));
	localparam logic signed [31:0] ATT_ONE = 32'(64'd1 << FRAC_BITS);
	localparam int H_SH = FRAC_BITS - 16;
	localparam logic [63:0] U_HALF = 64'd1 << (FRAC_BITS - 1);
	localparam int M_SH = 2 * FRAC_BITS - 31;
	localparam logic [63:0] M_HALF = 64'd1 << (M_SH - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_H_MUL, S_H_MULW, S_H_DIV, S_H_DIVW, S_H_SAT,
		S_U_MUL, S_U_MULW, S_U_ACC, S_MAG, S_SHIFT,
		S_N_MUL, S_N_MULW, S_N_ACC, S_SQRT, S_SQRTW,
		S_Q_DIV, S_Q_DIVW, S_Q_STORE, S_M_MUL, S_M_MULW, S_M_ACC, S_EMIT
	} state_t;

	state_t state_q;
	logic [5:0] cnt_q;
	logic [4:0] idx_q;

	logic [GAP_W-1:0]  gap_q;
	logic [TIME_W-1:0] ws_q, wstop_q, prev_time_q;
	logic signed [RATE_BITS-1:0] prev_rate_q [3];
	logic have_prev_q, first_late_q, skip_q;
	logic signed [31:0] att_q [4];
	logic signed [MAT_W-1:0] mat_q [9];

	// datapath
	logic signed [RATE_BITS:0] s_q [3];
	logic [GAP_W-1:0] dt_q;
	logic signed [31:0] h_q [3];
	logic signed [35:0] u_q [4];
	logic [34:0] mag_q [4];
	logic [63:0] n2_q;
	logic signed [63:0] acc_q;
	logic [31:0] mul_a_q;
	logic [63:0] mul_p_q;
	logic        mul_neg_q;
	logic [63:0] div_dq_q;
	logic [31:0] div_rem_q, div_dv_q;
	logic [63:0] sq_n_q;
	logic [33:0] sq_rem_q;
	logic [31:0] sq_root_q;

	// input fields
	logic [TIME_W-1:0] t_in, wend_in, dt_w;
	logic [31:0] r_tmp [3];
	logic signed [RATE_BITS-1:0] r_in [3];
	logic signed [RATE_BITS:0] s_in [3];
	logic in_xfer, pair_ok, go_int, fin_skip;

	assign t_in    = s_tdata[TIME_W-1:0];
	assign wend_in = s_tdata[2*TIME_W-1:TIME_W];
	assign dt_w    = t_in - prev_time_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_tmp[i] = (({16'b0, s_tdata[2*TIME_W+RATE_W*i +: RATE_W]} & R_MASK) ^ R_SIGN)
				- R_SIGN;
			r_in[i] = r_tmp[i][RATE_BITS-1:0];
			s_in[i] = {prev_rate_q[i][RATE_BITS-1], prev_rate_q[i]} + {r_in[i][RATE_BITS-1], r_in[i]};
		end
	end

	assign in_xfer = s_tvalid && s_tready;
	assign pair_ok = (prev_time_q >= ws_q) && (t_in <= wstop_q) && (t_in > prev_time_q)
		&& (dt_w[TIME_W-1:GAP_W] == '0) && (dt_w[GAP_W-1:0] < gap_q);
	assign go_int   = in_xfer && (s_tuser == KIND_SAMPLE) && have_prev_q && pair_ok;
	assign fin_skip = !have_prev_q || first_late_q;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// multiplier operand selection
	u_term_t ut;
	m_term_t mt;
	logic [RATE_BITS:0] s_abs_w;
	logic [31:0] mul_a_w, mul_b_w;
	logic mul_neg_w, mul_start;

	assign ut = u_term(idx_q[3:0]);
	assign mt = m_term(idx_q);
	assign s_abs_w = s_q[idx_q[1:0]][RATE_BITS] ? (RATE_BITS+1)'(0) - s_q[idx_q[1:0]]
		: s_q[idx_q[1:0]];

	always_comb begin
		mul_a_w   = '0;
		mul_b_w   = '0;
		mul_neg_w = 1'b0;
		mul_start = 1'b0;
		unique case (state_q)
			S_H_MUL: begin
				mul_start = 1'b1;
				mul_a_w   = {{(31-RATE_BITS){1'b0}}, s_abs_w};
				mul_b_w   = {{(32-GAP_W){1'b0}}, dt_q};
				mul_neg_w = s_q[idx_q[1:0]][RATE_BITS];
			end
			S_U_MUL: begin
				mul_start = 1'b1;
				mul_a_w   = abs32(h_q[ut.hsel]);
				mul_b_w   = abs32(att_q[ut.qsel]);
				mul_neg_w = h_q[ut.hsel][31] ^ att_q[ut.qsel][31] ^ ut.neg;
			end
			S_N_MUL: begin
				mul_start = 1'b1;
				mul_a_w   = mag_q[idx_q[1:0]][31:0];
				mul_b_w   = mag_q[idx_q[1:0]][31:0];
			end
			S_M_MUL: begin
				mul_start = 1'b1;
				mul_a_w   = abs32(att_q[mt.asel]);
				mul_b_w   = abs32(att_q[mt.bsel]);
				mul_neg_w = att_q[mt.asel][31] ^ att_q[mt.bsel][31] ^ mt.sub;
			end
			default: begin end
		endcase
	end

	// serial step logic
	logic [32:0] mul_sum;
	logic [32:0] div_cand, div_diff;
	logic        div_ge;
	logic [35:0] sq_cand, sq_trial;
	logic        sq_ge;

	assign mul_sum  = {1'b0, mul_p_q[63:32]} + (mul_p_q[0] ? {1'b0, mul_a_q} : 33'd0);
	assign div_cand = {div_rem_q, div_dq_q[63]};
	assign div_ge   = div_cand >= {1'b0, div_dv_q};
	assign div_diff = div_cand - {1'b0, div_dv_q};
	assign sq_cand  = {sq_rem_q, sq_n_q[63:62]};
	assign sq_trial = {2'b0, sq_root_q, 2'b01};
	assign sq_ge    = sq_cand >= sq_trial;

	// product rounding, saturation and matrix element
	logic [63:0] u_rnd_w, q_num_w, h_quo_w;
	logic signed [35:0] u_t;
	logic [31:0] h_sat_w;
	logic signed [63:0] m_p_s, acc_sum, m_mag;
	logic [63:0] m_rnd;
	logic signed [35:0] m_val, m_fin;
	logic big_w;

	assign u_rnd_w = (mul_p_q + U_HALF) >> FRAC_BITS;
	assign u_t     = signed'(u_rnd_w[35:0]);
	assign h_quo_w = div_dq_q;
	assign h_sat_w = (h_quo_w > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : h_quo_w[31:0];
	assign q_num_w = ({29'b0, mag_q[idx_q[1:0]]} << FRAC_BITS) + {33'b0, sq_root_q[31:1]};
	assign m_p_s   = signed'(mul_p_q);
	assign acc_sum = acc_q + (mul_neg_q ? -m_p_s : m_p_s);
	assign m_mag   = acc_sum[63] ? -acc_sum : acc_sum;
	assign m_rnd   = (64'(m_mag) + M_HALF) >> M_SH;

	always_comb begin
		m_val = acc_sum[63] ? -signed'(m_rnd[35:0]) : signed'(m_rnd[35:0]);
		if (mt.diag) begin
			m_val = ONE_Q30 - m_val;
		end
		if (m_val > ONE_Q30) begin
			m_fin = ONE_Q30;
		end else if (m_val < -ONE_Q30) begin
			m_fin = -ONE_Q30;
		end else begin
			m_fin = m_val;
		end
	end

	always_comb begin
		big_w = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (mag_q[i][34:31] != '0) begin
				big_w = 1'b1;
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (mul_start) begin
			mul_a_q   <= mul_a_w;
			mul_p_q   <= {32'b0, mul_b_w};
			mul_neg_q <= mul_neg_w;
		end else if (state_q == S_H_MULW || state_q == S_U_MULW || state_q == S_N_MULW
			|| state_q == S_M_MULW) begin
			mul_p_q <= {mul_sum, mul_p_q[31:1]};
		end

		if (state_q == S_H_DIV) begin
			div_dq_q  <= (mul_p_q << H_SH) + H_ROUND;
			div_rem_q <= '0;
			div_dv_q  <= H_DIVISOR;
		end else if (state_q == S_Q_DIV) begin
			div_dq_q  <= q_num_w;
			div_rem_q <= '0;
			div_dv_q  <= sq_root_q;
		end else if (state_q == S_H_DIVW || state_q == S_Q_DIVW) begin
			div_dq_q  <= {div_dq_q[62:0], div_ge};
			div_rem_q <= div_ge ? div_diff[31:0] : div_cand[31:0];
		end

		if (state_q == S_SQRT) begin
			sq_n_q    <= n2_q;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (state_q == S_SQRTW) begin
			sq_n_q    <= {sq_n_q[61:0], 2'b00};
			sq_rem_q  <= sq_ge ? 34'(sq_cand - sq_trial) : sq_cand[33:0];
			sq_root_q <= {sq_root_q[30:0], sq_ge};
		end

		if (go_int) begin
			s_q  <= s_in;
			dt_q <= dt_w[GAP_W-1:0];
			for (int i = 0; i < 4; i++) begin
				u_q[i] <= 36'(att_q[i]);
			end
		end

		if (state_q == S_H_SAT) begin
			h_q[idx_q[1:0]] <= mul_neg_q ? -signed'(h_sat_w) : signed'(h_sat_w);
		end

		if (state_q == S_U_ACC) begin
			u_q[ut.tgt] <= u_q[ut.tgt] + (mul_neg_q ? -u_t : u_t);
		end

		if (state_q == S_MAG) begin
			n2_q <= '0;
			for (int i = 0; i < 4; i++) begin
				mag_q[i] <= u_q[i][35] ? 35'(-u_q[i]) : u_q[i][34:0];
			end
		end else if (state_q == S_SHIFT && big_w) begin
			for (int i = 0; i < 4; i++) begin
				mag_q[i] <= mag_q[i] >> 1;
			end
		end

		if (state_q == S_N_ACC) begin
			n2_q <= n2_q + mul_p_q;
		end

		if (state_q == S_IDLE) begin
			acc_q <= '0;
		end else if (state_q == S_M_ACC) begin
			acc_q <= idx_q[0] ? 64'sd0 : acc_sum;
		end
	end

	// sequencer, architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
			skip_q       <= 1'b0;
			gap_q        <= GAP_RESET;
			ws_q         <= '0;
			wstop_q      <= '0;
			prev_time_q  <= '0;
			have_prev_q  <= 1'b0;
			first_late_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				prev_rate_q[i] <= '0;
			end
			for (int e = 0; e < 9; e++) begin
				mat_q[e] <= '0;
			end
			att_q[0] <= '0;
			att_q[1] <= '0;
			att_q[2] <= '0;
			att_q[3] <= ATT_ONE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				gap_q <= cfg_data;
			end
			// in S_EMIT the output register is reloaded below
			if (m_tvalid && m_tready && state_q != S_EMIT) begin
				m_tvalid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (s_tuser)
							KIND_BEGIN: begin
								ws_q         <= t_in;
								wstop_q      <= wend_in;
								have_prev_q  <= 1'b0;
								first_late_q <= 1'b0;
								att_q[0]     <= '0;
								att_q[1]     <= '0;
								att_q[2]     <= '0;
								att_q[3]     <= ATT_ONE;
							end
							KIND_SAMPLE: begin
								if (!have_prev_q) begin
									first_late_q <= t_in > ws_q;
									have_prev_q  <= 1'b1;
								end
								prev_time_q <= t_in;
								prev_rate_q <= r_in;
								if (go_int) begin
									idx_q   <= '0;
									state_q <= S_H_MUL;
								end
							end
							KIND_FINISH: begin
								skip_q <= fin_skip;
								idx_q  <= '0;
								if (fin_skip) begin
									for (int e = 0; e < 9; e++) begin
										mat_q[e] <= (e % 4 == 0) ? 32'(ONE_Q30) : '0;
									end
									state_q <= S_EMIT;
								end else begin
									state_q <= S_M_MUL;
								end
							end
							default: begin end
						endcase
					end
				end
				S_H_MUL: begin
					cnt_q   <= '0;
					state_q <= S_H_MULW;
				end
				S_H_MULW: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_H_DIV;
				end
				S_H_DIV: begin
					cnt_q   <= '0;
					state_q <= S_H_DIVW;
				end
				S_H_DIVW: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_H_SAT;
				end
				S_H_SAT: begin
					if (idx_q == 5'd2) begin
						idx_q   <= '0;
						state_q <= S_U_MUL;
					end else begin
						idx_q   <= idx_q + 5'd1;
						state_q <= S_H_MUL;
					end
				end
				S_U_MUL: begin
					cnt_q   <= '0;
					state_q <= S_U_MULW;
				end
				S_U_MULW: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_U_ACC;
				end
				S_U_ACC: begin
					if (idx_q == 5'd11) begin
						state_q <= S_MAG;
					end else begin
						idx_q   <= idx_q + 5'd1;
						state_q <= S_U_MUL;
					end
				end
				S_MAG: begin
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					// halve all four magnitudes until each fits in 31 bits
					if (!big_w) begin
						idx_q   <= '0;
						state_q <= S_N_MUL;
					end
				end
				S_N_MUL: begin
					cnt_q   <= '0;
					state_q <= S_N_MULW;
				end
				S_N_MULW: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_N_ACC;
				end
				S_N_ACC: begin
					if (idx_q == 5'd3) begin
						state_q <= S_SQRT;
					end else begin
						idx_q   <= idx_q + 5'd1;
						state_q <= S_N_MUL;
					end
				end
				S_SQRT: begin
					cnt_q   <= '0;
					state_q <= S_SQRTW;
				end
				S_SQRTW: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						idx_q   <= '0;
						state_q <= S_Q_DIV;
					end
				end
				S_Q_DIV: begin
					// zero norm leaves the attitude as it was
					cnt_q   <= '0;
					state_q <= (sq_root_q == '0) ? S_IDLE : S_Q_DIVW;
				end
				S_Q_DIVW: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_Q_STORE;
				end
				S_Q_STORE: begin
					att_q[idx_q[1:0]] <= u_q[idx_q[1:0]][35] ? -signed'(div_dq_q[31:0])
						: signed'(div_dq_q[31:0]);
					if (idx_q == 5'd3) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 5'd1;
						state_q <= S_Q_DIV;
					end
				end
				S_M_MUL: begin
					cnt_q   <= '0;
					state_q <= S_M_MULW;
				end
				S_M_MULW: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_M_ACC;
				end
				S_M_ACC: begin
					if (idx_q[0]) begin
						mat_q[idx_q[4:1]] <= m_fin[31:0];
					end
					if (idx_q == 5'd17) begin
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q + 5'd1;
						state_q <= S_M_MUL;
					end
				end
				S_EMIT: begin
					if (!m_tvalid || m_tready) begin
						for (int e = 0; e < 9; e++) begin
							m_tdata[MAT_W*e +: MAT_W] <= mat_q[e];
						end
						m_tuser[0] <= skip_q;
						m_tvalid   <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (s_tuser == KIND_FINISH) |=> !s_tready)
		else $error("finish transfer did not hold off the input");

	a_skip_identity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[31:0] == 32'h4000_0000)
			&& (m_tdata[63:32] == 32'h0) && (m_tdata[159:128] == 32'h4000_0000)
			&& (m_tdata[287:256] == 32'h4000_0000))
		else $error("skipped result is not identity");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sh4000_0000)
			&& ($signed(m_tdata[31:0]) >= -32'sh4000_0000))
		else $error("matrix element outside clamp range");

	a_att_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(att_q[3] <= ATT_ONE) && (att_q[3] >= -ATT_ONE))
		else $error("attitude w outside unit range");

endmodule
